@@ rtl/cofs_pkg.sv @@
// shared types, codes and constants of the clock offset estimator
package cofs_pkg;

  // field widths
  localparam int TIME_W   = 64;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;

  // samples averaged before the offset is reported (2 .. 255)
  localparam int SAMPLE_COUNT = 30;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // constant divider: one quotient digit per cycle by reciprocal multiplication
  localparam int DIGIT_W   = 16;
  localparam int DIV_STEPS = TIME_W / DIGIT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int REM_W     = $clog2(SAMPLE_COUNT);
  localparam int PART_W    = REM_W + DIGIT_W;
  localparam int RECIP_SH  = PART_W + REM_W;
  localparam int RECIP_W   = PART_W + 1;
  localparam int PROD_W    = PART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  // opcodes of an input word
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RESP = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ISSUED    = 3'd0,
    STAT_IGNORED   = 3'd1,
    STAT_ACCEPTED  = 3'd2,
    STAT_RESTARTED = 3'd3,
    STAT_SYNCED    = 3'd4
  } status_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_ACCUM = 2'd1,
    K_CLEAR = 2'd2,
    K_FINAL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [ID_W-1:0]    send_id;
    logic               ahead;
    logic [TIME_W-1:0]  ping;
    logic [TIME_W-1:0]  abs_diff;
  } entry_t;

endpackage

@@ rtl/cofs_if.sv @@
// valid/ready channel interfaces for input and result words
interface cofs_in_if;
  import cofs_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] now_time;
  logic [ID_W-1:0]   resp_id;
  logic [TIME_W-1:0] server_time;

  modport source (output valid, output opcode, output now_time, output resp_id,
                  output server_time, input ready);
  modport sink (input valid, input opcode, input now_time, input resp_id,
                input server_time, output ready);
endinterface

interface cofs_out_if;
  import cofs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     send_id;
  logic [TIME_W-1:0]   time_delta;
  logic [TIME_W-1:0]   mean_ping;

  modport source (output valid, output status, output send_id, output time_delta,
                  output mean_ping, input ready);
  modport sink (input valid, input status, input send_id, input time_delta,
                input mean_ping, output ready);
endinterface

@@ rtl/cofs_front.sv @@
// front: accepts input words, tracks the exchange state and classifies each word
module cofs_front (
  input  logic             clk,
  input  logic             rst_n,
  cofs_in_if.sink          in_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output cofs_pkg::entry_t push_entry
);
  import cofs_pkg::*;

  logic [ID_W-1:0]   exp_id_r, exp_id_nxt;
  logic [TIME_W-1:0] sent_time_r, sent_time_nxt;
  logic              server_ahead_r, server_ahead_nxt;
  logic              done_r, done_nxt;
  logic              ahead_now;
  logic              in_fire;
  logic [ID_W:0]     count_inc;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign in_fire     = in_ch.valid && push_ready;

  assign ahead_now = in_ch.server_time >= in_ch.now_time;
  assign count_inc = {1'b0, exp_id_r} + {{ID_W{1'b0}}, 1'b1};

  // classify the word and work out the next exchange state
  always_comb begin
    exp_id_nxt       = exp_id_r;
    sent_time_nxt    = sent_time_r;
    server_ahead_nxt = server_ahead_r;
    done_nxt         = done_r;

    push_entry.kind     = K_NONE;
    push_entry.status   = STAT_IGNORED;
    push_entry.ahead    = server_ahead_r;
    push_entry.ping     = in_ch.now_time - sent_time_r;
    push_entry.abs_diff = ahead_now ? (in_ch.server_time - in_ch.now_time)
                                    : (in_ch.now_time - in_ch.server_time);

    if (in_ch.opcode == OP_SEND) begin
      if (!done_r) begin
        sent_time_nxt     = in_ch.now_time;
        push_entry.status = STAT_ISSUED;
      end
    end else if (!done_r && (in_ch.resp_id == exp_id_r)) begin
      if ((exp_id_r != '0) && (ahead_now != server_ahead_r)) begin
        // sign flipped against the run: start over
        exp_id_nxt        = '0;
        push_entry.kind   = K_CLEAR;
        push_entry.status = STAT_RESTARTED;
      end else begin
        if (exp_id_r == '0) begin
          server_ahead_nxt = ahead_now;
        end
        push_entry.ahead = server_ahead_nxt;
        if (count_inc >= (ID_W+1)'(SAMPLE_COUNT)) begin
          done_nxt          = 1'b1;
          push_entry.kind   = K_FINAL;
          push_entry.status = STAT_SYNCED;
        end else begin
          exp_id_nxt        = count_inc[ID_W-1:0];
          push_entry.kind   = K_ACCUM;
          push_entry.status = STAT_ACCEPTED;
        end
      end
    end

    push_entry.send_id = exp_id_nxt;
  end

  // exchange state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r       <= '0;
      sent_time_r    <= '0;
      server_ahead_r <= 1'b0;
      done_r         <= 1'b0;
    end else if (in_fire) begin
      exp_id_r       <= exp_id_nxt;
      sent_time_r    <= sent_time_nxt;
      server_ahead_r <= server_ahead_nxt;
      done_r         <= done_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("sync flag cleared after synchronization");

  a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_id_r < ID_W'(SAMPLE_COUNT))
    else $error("expected id reached the sample count");

  a_final_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (push_entry.kind == K_FINAL)) |=> done_r)
    else $error("final sample did not mark the block synchronized");
`endif

endmodule

@@ rtl/cofs_queue.sv @@
// two-entry queue between front and back
module cofs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  cofs_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output cofs_pkg::entry_t pop_entry
);
  import cofs_pkg::*;

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push_fire, pop_fire;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/cofs_back.sv @@
// back: keeps the running sums, divides for the means and holds the result word
module cofs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cofs_pkg::entry_t pop_entry,
  cofs_out_if.source       out_ch
);
  import cofs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  localparam logic [PART_W-1:0] DIVISOR = PART_W'(SAMPLE_COUNT);

  state_t              state_r, state_nxt;
  logic [DCNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [TIME_W-1:0]   offset_sum_r, offset_sum_nxt;
  logic [TIME_W-1:0]   ping_sum_r, ping_sum_nxt;
  logic [TIME_W-1:0]   q_off_r, q_off_nxt, q_ping_r, q_ping_nxt;
  logic [REM_W-1:0]    rem_off_r, rem_off_nxt, rem_ping_r, rem_ping_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_delta_r, out_delta_nxt;
  logic [TIME_W-1:0]   out_ping_r, out_ping_nxt;
  logic                ahead_r, ahead_nxt;
  logic [TIME_W-1:0]   sample_add;
  logic [PART_W-1:0]   part_off, part_ping;
  logic [PROD_W-1:0]   prod_off, prod_ping;
  logic [DIGIT_W-1:0]  dig_off, dig_ping;
  logic [PART_W-1:0]   left_off, left_ping;
  logic                pop_fire;

  assign pop_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign pop_fire  = pop_valid && pop_ready;

  assign sample_add = pop_entry.abs_diff + (pop_entry.ping >> 1);

  // one quotient digit per step: remainder and next digit times the reciprocal
  assign part_off  = {rem_off_r, q_off_r[TIME_W-1 -: DIGIT_W]};
  assign part_ping = {rem_ping_r, q_ping_r[TIME_W-1 -: DIGIT_W]};
  assign prod_off  = PROD_W'(part_off) * PROD_W'(RECIP);
  assign prod_ping = PROD_W'(part_ping) * PROD_W'(RECIP);
  assign dig_off   = prod_off[RECIP_SH +: DIGIT_W];
  assign dig_ping  = prod_ping[RECIP_SH +: DIGIT_W];
  assign left_off  = part_off - PART_W'(dig_off) * DIVISOR;
  assign left_ping = part_ping - PART_W'(dig_ping) * DIVISOR;

  always_comb begin
    state_nxt      = state_r;
    div_cnt_nxt    = div_cnt_r;
    offset_sum_nxt = offset_sum_r;
    ping_sum_nxt   = ping_sum_r;
    q_off_nxt      = q_off_r;
    q_ping_nxt     = q_ping_r;
    rem_off_nxt    = rem_off_r;
    rem_ping_nxt   = rem_ping_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_delta_nxt  = out_delta_r;
    out_ping_nxt   = out_ping_r;
    ahead_nxt      = ahead_r;

    case (state_r)
      ST_IDLE: begin
        if (pop_fire) begin
          out_status_nxt = pop_entry.status;
          out_id_nxt     = pop_entry.send_id;
          out_delta_nxt  = '0;
          out_ping_nxt   = '0;
          case (pop_entry.kind)
            K_ACCUM: begin
              offset_sum_nxt = offset_sum_r + sample_add;
              ping_sum_nxt   = ping_sum_r + pop_entry.ping;
              out_valid_nxt  = 1'b1;
            end
            K_CLEAR: begin
              offset_sum_nxt = '0;
              ping_sum_nxt   = '0;
              out_valid_nxt  = 1'b1;
            end
            K_FINAL: begin
              // last sample goes straight into the divider
              q_off_nxt    = offset_sum_r + sample_add;
              q_ping_nxt   = ping_sum_r + pop_entry.ping;
              rem_off_nxt  = '0;
              rem_ping_nxt = '0;
              div_cnt_nxt  = '0;
              ahead_nxt    = pop_entry.ahead;
              state_nxt    = ST_DIV;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        q_off_nxt    = {q_off_r[TIME_W-DIGIT_W-1:0], dig_off};
        q_ping_nxt   = {q_ping_r[TIME_W-DIGIT_W-1:0], dig_ping};
        rem_off_nxt  = left_off[REM_W-1:0];
        rem_ping_nxt = left_ping[REM_W-1:0];
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_STEPS-1)) begin
          out_delta_nxt = ahead_r ? q_off_nxt : ~q_off_nxt;
          out_ping_nxt  = q_ping_nxt;
          out_valid_nxt = 1'b1;
          div_cnt_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      offset_sum_r <= '0;
      ping_sum_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      offset_sum_r <= offset_sum_nxt;
      ping_sum_r   <= ping_sum_nxt;
    end
  end

  // divider and result payload
  always_ff @(posedge clk) begin
    q_off_r      <= q_off_nxt;
    q_ping_r     <= q_ping_nxt;
    rem_off_r    <= rem_off_nxt;
    rem_ping_r   <= rem_ping_nxt;
    ahead_r      <= ahead_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_delta_r  <= out_delta_nxt;
    out_ping_r   <= out_ping_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.send_id    = out_id_r;
  assign out_ch.time_delta = out_delta_r;
  assign out_ch.mean_ping  = out_ping_r;

`ifndef SYNTHESIS
  a_no_pop_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !pop_ready)
    else $error("queue popped while the divider runs");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, rem_off_r} < (REM_W+1)'(SAMPLE_COUNT)) &&
                            ({1'b0, rem_ping_r} < (REM_W+1)'(SAMPLE_COUNT)))
    else $error("divider remainder out of range");

  a_div_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && (div_cnt_r == DCNT_W'(DIV_STEPS-1))) |=>
      (out_valid_r && (state_r == ST_IDLE)))
    else $error("divider finished without presenting a result");

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (div_cnt_r == '0))
    else $error("divider step count not cleared while idle");
`endif

endmodule

@@ rtl/clock_offset_estimator_unit.sv @@
// Clock offset estimator: averages ping samples into a clock offset and mean round trip.
// The block takes one word per cycle on in_ch while the queue has room and gives
// exactly one result word per input word on out_ch, in order. A front stage tracks
// the request id, send time and sign of the first sample and classifies each word; a
// two-entry queue hands the work to a back stage that keeps the 64-bit offset and ping
// sums and a result register, so a waiting result does not stop new words until the
// queue fills. The word that completes the run gets its means from a constant divider
// that makes one 16-bit quotient digit per cycle by reciprocal multiplication, so that
// result appears later than an ordinary one, and the back stage takes no other work
// while it divides. After it every word is reported ignored.
module clock_offset_estimator_unit (
  input  logic     clk,
  input  logic     rst_n,
  cofs_in_if.sink  in_ch,
  cofs_out_if.source out_ch
);
  import cofs_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // classify and track exchange state
  cofs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decouple front and back
  cofs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // sums, divider and result word
  cofs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

@@ test/tb_clock_offset_estimator_unit.sv @@
// testbench for clock_offset_estimator_unit: random ping exchanges checked against an offset predictor
module tb_clock_offset_estimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cofs_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int FIRST_TARGET = 900;
  localparam int WORD_TARGET  = 1750;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   send_id;
    logic [TIME_W-1:0] time_delta;
    logic [TIME_W-1:0] mean_ping;
  } report_t;

  logic clk;
  logic rst_n;

  cofs_in_if  in_ch ();
  cofs_out_if out_ch ();

  clock_offset_estimator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted estimator state
  logic [ID_W-1:0]   est_id;
  logic [TIME_W-1:0] est_sent;
  logic              est_ahead;
  logic [TIME_W-1:0] est_offset_sum;
  logic [TIME_W-1:0] est_ping_sum;
  logic [7:0]        est_samples;
  logic              est_synced;

  report_t awaited_reports[$];
  int      fail_count;
  int      words_sent;
  int      cycle_count;
  int      hold_request;
  bit      gaps_on;
  int      burst_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // expected result of one accepted word, advancing the predicted state
  function automatic report_t estimate_report(input logic op, input logic [TIME_W-1:0] now,
                                              input logic [ID_W-1:0] rid,
                                              input logic [TIME_W-1:0] srv);
    report_t           rep;
    logic [TIME_W-1:0] rtt;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] avg;
    logic              ahead;
    rep.status     = STAT_IGNORED;
    rep.time_delta = '0;
    rep.mean_ping  = '0;
    if (op == OP_SEND) begin
      if (!est_synced) begin
        est_sent   = now;
        rep.status = STAT_ISSUED;
      end
    end else if (!est_synced && rid == est_id) begin
      rtt   = now - est_sent;
      ahead = (srv >= now);
      if (est_id == '0) begin
        est_ahead = ahead;
      end
      if (est_id != '0 && ahead != est_ahead) begin
        // sign flipped: the run starts over
        est_id         = '0;
        est_offset_sum = '0;
        est_ping_sum   = '0;
        est_samples    = '0;
        rep.status     = STAT_RESTARTED;
      end else begin
        diff           = (ahead ? (srv - now) : (now - srv)) + (rtt >> 1);
        est_ping_sum   = est_ping_sum + rtt;
        est_offset_sum = est_offset_sum + diff;
        est_samples    = est_samples + 8'd1;
        if (est_samples >= SAMPLE_COUNT) begin
          avg            = est_offset_sum / 64'(est_samples);
          rep.mean_ping  = est_ping_sum / 64'(est_samples);
          rep.time_delta = est_ahead ? avg : ~avg;
          rep.status     = STAT_SYNCED;
          est_synced     = 1'b1;
        end else begin
          est_id     = est_id + 8'd1;
          rep.status = STAT_ACCEPTED;
        end
      end
    end
    rep.send_id = est_id;
    return rep;
  endfunction

  // send one word, predict its result once accepted, then maybe pause the burst
  task automatic send_word(input logic op, input logic [TIME_W-1:0] now,
                           input logic [ID_W-1:0] rid, input logic [TIME_W-1:0] srv);
    int      gap;
    report_t rep;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.now_time    <= now;
    in_ch.resp_id     <= rid;
    in_ch.server_time <= srv;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rep = estimate_report(op, now, rid, srv);
    awaited_reports = {awaited_reports, rep};
    words_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return '1 - 64'($urandom_range(0, 1000));
      1:       return 64'($urandom_range(0, 5000));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_span();
    return ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 2000));
  endfunction

  // server time on the wanted side of now (now must be nonzero for behind)
  function automatic logic [TIME_W-1:0] place_server_time(input logic [TIME_W-1:0] now,
                                                          input bit want_ahead);
    logic [TIME_W-1:0] off;
    logic [TIME_W-1:0] srv;
    off = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 100000));
    if (want_ahead) begin
      srv = now + off;
      if (srv < now) srv = '1;
    end else begin
      srv = (off >= now) ? '0 : now - off - 1;
    end
    return srv;
  endfunction

  // request followed by its matching response
  task automatic run_exchange(input bit want_ahead);
    logic [TIME_W-1:0] t_send;
    logic [TIME_W-1:0] t_resp;
    t_send = pick_time();
    t_resp = t_send + pick_span();
    if (!want_ahead && t_resp == '0) t_resp = 64'd1;
    send_word(OP_SEND, t_send, 8'($urandom_range(0, 255)), rand64());
    send_word(OP_RESP, t_resp, est_id, place_server_time(t_resp, want_ahead));
  endtask

  // one random step; a run about to complete is broken by a sign flip
  task automatic random_step();
    int pick;
    if (est_samples == SAMPLE_COUNT - 1) begin
      run_exchange(!est_ahead);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (est_id == '0) run_exchange(1'($urandom_range(0, 1)));
        else run_exchange((pick < 2) ? !est_ahead : est_ahead);
      end else if (pick < 70) begin
        send_word(OP_RESP, rand64(), 8'(est_id + $urandom_range(1, 255)), rand64());
      end else if (pick < 78) begin
        send_word(OP_SEND, rand64(), 8'($urandom_range(0, 255)), rand64());
      end else if (pick < 93) begin
        send_word(1'($urandom_range(0, 1)), rand64(), 8'($urandom_range(0, 255)), rand64());
      end else begin
        send_word(OP_RESP, rand64(), est_id, rand64());
      end
    end
  endtask

  task automatic test_directed();
    logic [TIME_W-1:0] mid;
    mid = 64'h8000_0000_0000_0000;
    // response with another id
    send_word(OP_RESP, rand64(), 8'hFF, rand64());
    // first sample with equal clocks at the top of the range
    send_word(OP_SEND, '0, 8'h00, '0);
    send_word(OP_RESP, '1, 8'h00, '1);
    // wrapped round trip, server behind: sign mismatch restarts
    send_word(OP_SEND, '1, 8'hFF, '1);
    send_word(OP_RESP, 64'd3, 8'h01, '0);
    // first sample of a run with the server behind
    send_word(OP_SEND, 64'd100, 8'h00, '0);
    send_word(OP_RESP, 64'd110, 8'h00, '0);
    send_word(OP_RESP, 64'd120, 8'h00, '0);
    send_word(OP_SEND, 64'd200, 8'h00, '0);
    send_word(OP_RESP, 64'd250, 8'h01, 64'd300);
    // new run, server ahead
    send_word(OP_SEND, mid, 8'h00, '0);
    send_word(OP_RESP, mid + 64'd20, 8'h00, mid + 64'd20);
    send_word(OP_SEND, mid, 8'h00, '0);
    send_word(OP_RESP, mid + 64'd7, 8'h01, '1);
    // response reusing the last send time, then one before its send
    send_word(OP_RESP, mid + 64'd9, 8'h02, mid + 64'd1009);
    send_word(OP_RESP, '0, 8'h03, '0);
    repeat (4) begin
      send_word(1'($urandom_range(0, 1)), rand64(), 8'($urandom_range(0, 255)), rand64());
    end
  endtask

  task automatic test_random_exchanges(input int target);
    while (words_sent < target) random_step();
  endtask

  // receiver holds off while words keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request++;
    repeat (60) random_step();
    gaps_on = 1'b1;
  endtask

  // clean run of agreeing samples up to synchronization
  task automatic test_synchronize();
    bit side;
    side = 1'($urandom_range(0, 1));
    if (est_id != '0) run_exchange(!est_ahead);
    while (!est_synced) begin
      if ($urandom_range(0, 5) == 0) begin
        send_word(OP_RESP, rand64(), 8'(est_id + $urandom_range(1, 255)), rand64());
      end
      run_exchange((est_id == '0) ? side : est_ahead);
    end
  endtask

  // everything is ignored once synchronized
  task automatic test_after_sync();
    repeat (20) begin
      send_word(1'($urandom_range(0, 1)), rand64(),
                $urandom_range(0, 1) ? est_id : 8'($urandom_range(0, 255)), rand64());
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : report_checker
    report_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d",
                 $time, out_ch.status);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("send_id", 64'(want.send_id), 64'(out_ch.send_id));
        check_field("time_delta", want.time_delta, out_ch.time_delta);
        check_field("mean_ping", want.mean_ping, out_ch.mean_ping);
      end
    end
  end

  // result receiver: stall modes that change over time, plus a long hold on request
  initial begin : result_receiver
    int     mode;
    int     mode_left;
    int     hold_left;
    int     hold_seen;
    int     phase;
    logic [7:0] pattern;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    phase     = 0;
    pattern   = 8'h5A;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
        pattern   = 8'($urandom_range(1, 255));
      end
      mode_left--;
      phase = (phase + 1) % 8;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= pattern[phase];
          2:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // main sequence
  initial begin
    fail_count     = 0;
    words_sent     = 0;
    hold_request   = 0;
    gaps_on        = 1'b1;
    burst_left     = 0;
    est_id         = '0;
    est_sent       = '0;
    est_ahead      = 1'b0;
    est_offset_sum = '0;
    est_ping_sum   = '0;
    est_samples    = '0;
    est_synced     = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_SEND;
    in_ch.now_time    <= '0;
    in_ch.resp_id     <= '0;
    in_ch.server_time <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_exchanges(FIRST_TARGET);
    test_backpressure();
    test_random_exchanges(WORD_TARGET);
    test_synchronize();
    test_after_sync();

    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cofs_pkg.sv
rtl/cofs_if.sv
rtl/cofs_front.sv
rtl/cofs_queue.sv
rtl/cofs_back.sv
rtl/clock_offset_estimator_unit.sv
test/tb_clock_offset_estimator_unit.sv
